@@ rtl/rau_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rau_pkg: shared types and constants for the rational arithmetic unit
// Holds the command and result word types, opcodes and status codes.
// ----------------------------------------------------------------------------
package rau_pkg;

	localparam int WORD_BITS = 32;
	localparam int FIT_BITS  = (WORD_BITS > 32) ? 32 : ((WORD_BITS < 2) ? 2 : WORD_BITS);
	localparam int MAG_BITS  = 64;
	localparam int MAG_CNT_BITS = 7;

	localparam logic [2:0] OP_NORM = 3'd0;
	localparam logic [2:0] OP_ADD  = 3'd1;
	localparam logic [2:0] OP_SUB  = 3'd2;
	localparam logic [2:0] OP_MUL  = 3'd3;
	localparam logic [2:0] OP_DIV  = 3'd4;
	localparam logic [2:0] OP_CMP  = 3'd5;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_ZDEN = 2'd1;
	localparam logic [1:0] ST_OVF  = 2'd2;

	typedef struct packed {
		logic [2:0]         opcode;
		logic signed [31:0] a_num;
		logic signed [31:0] a_den;
		logic signed [31:0] b_num;
		logic signed [31:0] b_den;
	} cmd_t;

	typedef struct packed {
		logic signed [31:0] res_num;
		logic [30:0]        res_den;
		logic               less;
		logic               equal;
		logic [1:0]         status;
	} res_t;

	// Requests to the shared divide unit.
	typedef struct packed {
		logic go;
		logic done;
	} div_ctl_t;

endpackage

@@ rtl/rau_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rau_div: iterative 64-bit unsigned restoring divider
// One quotient bit per cycle; remainder returned alongside the quotient.
// ----------------------------------------------------------------------------
module rau_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        go,
	input  logic [rau_pkg::MAG_BITS-1:0] dividend,
	input  logic [rau_pkg::MAG_BITS-1:0] divisor,
	output logic [rau_pkg::MAG_BITS-1:0] quot,
	output logic [rau_pkg::MAG_BITS-1:0] rem,
	output logic                        done
);
	import rau_pkg::*;

	logic [MAG_BITS-1:0]     quot_q, rem_q, den_q;
	logic [MAG_CNT_BITS-1:0] cnt_q;
	logic                    run_q, done_q;
	logic [MAG_BITS:0]       shifted, diff;

	assign shifted = {rem_q, quot_q[MAG_BITS-1]};
	assign diff    = shifted - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= !go && run_q && (cnt_q == MAG_CNT_BITS'(MAG_BITS - 1));
			if (go) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == MAG_CNT_BITS'(MAG_BITS - 1))
					run_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			quot_q <= dividend;
			rem_q  <= '0;
			den_q  <= divisor;
		end else if (run_q) begin
			if (!diff[MAG_BITS]) begin
				rem_q  <= diff[MAG_BITS-1:0];
				quot_q <= {quot_q[MAG_BITS-2:0], 1'b1};
			end else begin
				rem_q  <= shifted[MAG_BITS-1:0];
				quot_q <= {quot_q[MAG_BITS-2:0], 1'b0};
			end
		end
	end

	assign quot = quot_q;
	assign rem  = rem_q;
	assign done = done_q;

	a_done_after_run: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(run_q)) else $error("divider done without run");
	a_no_go_while_run: assert property (@(posedge clk) disable iff (!arst_n)
		run_q |-> !go) else $error("divider restarted while busy");
	a_done_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q) else $error("divider done held");

endmodule

@@ rtl/rational_arithmetic_unit_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rational_arithmetic_unit_core: exact rational normalize/add/sub/mul/div/compare
// Steps: an unused opcode or a zero denominator ends at once; else the cross
// products are formed (not for normalize), compare ends there, and for a nonzero
// numerator the gcd runs Euclid steps on the shared divider (at most about 92),
// then the divider reduces numerator and denominator before the output state.
// One word at a time: busy covers the done cycle, so the next word is taken in the
// cycle after done at the earliest. Reset clears the sequencer and the strobe;
// the receiver cannot stall.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit_core (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  rau_pkg::cmd_t cmd,
	output logic          busy,
	output logic          done,
	output rau_pkg::res_t res
);
	import rau_pkg::*;

	// Sequencer states. The cross products are built with one shared 32x32
	// multiplier, one product per cycle. The gcd runs Euclid's algorithm on
	// the shared divider, then the divider reduces numerator and denominator.
	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_M0   = 4'd1;
	localparam logic [3:0] S_M1   = 4'd2;
	localparam logic [3:0] S_M2   = 4'd3;
	localparam logic [3:0] S_COMB = 4'd4;
	localparam logic [3:0] S_GCD  = 4'd5;
	localparam logic [3:0] S_GWT  = 4'd6;
	localparam logic [3:0] S_DN   = 4'd7;
	localparam logic [3:0] S_DNW  = 4'd8;
	localparam logic [3:0] S_DD   = 4'd9;
	localparam logic [3:0] S_DDW  = 4'd10;
	localparam logic [3:0] S_OUT  = 4'd11;

	logic [3:0] state_q;
	logic [2:0] op_q;
	logic       an_s, ad_s, bn_s, bd_s;
	logic [31:0] an_m, ad_m, bn_m, bd_m;
	logic [MAG_BITS-1:0] p0_q, p1_q, p2_q;
	logic       p0n_q, p1n_q, p2n_q;
	logic [MAG_BITS-1:0] n_q, d_q, gx_q, gy_q, g_q, nr_q;
	logic       nn_q, dn_q;
	logic       done_q;
	res_t       res_q;

	logic [31:0] mx, my;
	logic        msign;
	logic [MAG_BITS-1:0] prod;
	logic [MAG_BITS-1:0] sum_mag;
	logic        sum_neg;
	logic        p1_eff;

	logic                div_go, div_done;
	logic [MAG_BITS-1:0] div_a, div_b, div_q, div_r;
	div_ctl_t            dctl;

	logic [MAG_BITS-1:0] lim;
	logic                neg_res, ovf;

	// A word is taken only when the unit is idle and no result is on the ports.
	logic                accept;
	// The offered word names a zero denominator and finishes at once.
	logic                cmd_zden;

	function automatic logic [31:0] mag32(input logic [31:0] v);
		mag32 = v[31] ? (~v + 32'd1) : v;
	endfunction

	assign an_m = mag32(cmd.a_num);
	assign ad_m = mag32(cmd.a_den);
	assign bn_m = mag32(cmd.b_num);
	assign bd_m = mag32(cmd.b_den);

	assign accept   = start && !busy;
	assign cmd_zden = (cmd.opcode <= OP_CMP) && (cmd.a_den == '0 ||
	    (cmd.opcode != OP_NORM && cmd.b_den == '0) ||
	    (cmd.opcode == OP_DIV && cmd.b_num == '0));

	// Operand registers, kept as sign and magnitude.
	logic [31:0] anm_q, adm_q, bnm_q, bdm_q;

	// Multiplier operand selection per state.
	always_comb begin
		mx = anm_q; my = bdm_q; msign = an_s ^ bd_s;
		case (state_q)
			S_M0: begin
				if (op_q == OP_MUL) begin
					mx = anm_q; my = bnm_q; msign = an_s ^ bn_s;
				end else begin
					mx = anm_q; my = bdm_q; msign = an_s ^ bd_s;
				end
			end
			S_M1: begin
				if (op_q == OP_DIV) begin
					mx = adm_q; my = bnm_q; msign = ad_s ^ bn_s;
				end else begin
					mx = bnm_q; my = adm_q; msign = bn_s ^ ad_s;
				end
			end
			S_M2: begin
				mx = adm_q; my = bdm_q; msign = ad_s ^ bd_s;
			end
			default: begin
				mx = anm_q; my = bdm_q; msign = an_s ^ bd_s;
			end
		endcase
	end

	assign prod = MAG_BITS'(mx) * MAG_BITS'(my);

	// Signed-magnitude add of p0 and (optionally negated) p1.
	assign p1_eff = (op_q == OP_ADD) ? p1n_q : ~p1n_q;
	always_comb begin
		if (p0n_q == p1_eff) begin
			sum_mag = p0_q + p1_q;
			sum_neg = p0n_q;
		end else if (p0_q >= p1_q) begin
			sum_mag = p0_q - p1_q;
			sum_neg = p0n_q;
		end else begin
			sum_mag = p1_q - p0_q;
			sum_neg = p1_eff;
		end
		if (sum_mag == '0)
			sum_neg = 1'b0;
	end

	// A zero numerator skips the gcd, so the divider is left idle then.
	always_comb begin
		div_go = 1'b0;
		div_a  = gx_q;
		div_b  = gy_q;
		case (state_q)
			S_GCD: begin
				div_go = (gy_q != '0) && (n_q != '0);
				div_a = gx_q; div_b = gy_q;
			end
			S_DN: begin
				div_go = 1'b1; div_a = n_q; div_b = g_q;
			end
			S_DD: begin
				div_go = 1'b1; div_a = d_q; div_b = g_q;
			end
			default: begin
				div_go = 1'b0;
			end
		endcase
	end

	rau_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (div_go),
		.dividend (div_a),
		.divisor  (div_b),
		.quot     (div_q),
		.rem      (div_r),
		.done     (div_done)
	);

	assign dctl.go   = div_go;
	assign dctl.done = div_done;

	assign lim     = MAG_BITS'(1) << (FIT_BITS - 1);
	assign neg_res = nn_q ^ dn_q;
	assign ovf     = (div_q > lim - 1) || (neg_res ? (nr_q > lim) : (nr_q > lim - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			// The strobe follows the output state, or comes at once for a word
			// that is rejected or carries an unused opcode.
			done_q <= (state_q == S_OUT) ||
			    (accept && (cmd.opcode > OP_CMP || cmd_zden));
			case (state_q)
				S_IDLE: begin
					if (accept && cmd.opcode <= OP_CMP && !cmd_zden) begin
						if (cmd.opcode == OP_NORM)
							state_q <= (cmd.a_num == '0) ? S_OUT : S_GCD;
						else
							state_q <= S_M0;
					end
				end
				S_M0: state_q <= S_M1;
				S_M1: state_q <= S_M2;
				S_M2: state_q <= S_COMB;
				S_COMB: state_q <= (op_q == OP_CMP) ? S_OUT : S_GCD;
				S_GCD: begin
					if (n_q == '0)
						state_q <= S_OUT;
					else if (gy_q == '0)
						state_q <= S_DN;
					else
						state_q <= S_GWT;
				end
				S_GWT: if (div_done) state_q <= S_GCD;
				S_DN:  state_q <= S_DNW;
				S_DNW: if (div_done) state_q <= S_DD;
				S_DD:  state_q <= S_DDW;
				S_DDW: if (div_done) state_q <= S_OUT;
				S_OUT: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				res_q.res_num <= '0;
				res_q.res_den <= '0;
				res_q.less    <= 1'b0;
				res_q.equal   <= 1'b0;
				res_q.status  <= cmd_zden ? ST_ZDEN : ST_OK;
				op_q  <= cmd.opcode;
				an_s <= cmd.a_num[31]; ad_s <= cmd.a_den[31];
				bn_s <= cmd.b_num[31]; bd_s <= cmd.b_den[31];
				anm_q <= an_m; adm_q <= ad_m; bnm_q <= bn_m; bdm_q <= bd_m;
				// Normalize of a nonzero numerator goes straight to the gcd with n = a_num, d = a_den.
				n_q  <= MAG_BITS'(an_m); nn_q <= cmd.a_num[31];
				d_q  <= MAG_BITS'(ad_m); dn_q <= cmd.a_den[31];
				gx_q <= MAG_BITS'(an_m); gy_q <= MAG_BITS'(ad_m);
			end
			S_M0: begin
				p0_q <= prod; p0n_q <= msign & (prod != '0);
			end
			S_M1: begin
				p1_q <= prod; p1n_q <= msign & (prod != '0);
			end
			S_M2: begin
				p2_q <= prod; p2n_q <= msign & (prod != '0);
			end
			S_COMB: begin
				if (op_q == OP_ADD || op_q == OP_SUB || op_q == OP_CMP) begin
					n_q <= sum_mag; nn_q <= sum_neg;
					gx_q <= sum_mag;
				end else begin
					n_q <= p0_q; nn_q <= p0n_q;
					gx_q <= p0_q;
				end
				if (op_q == OP_DIV) begin
					d_q <= p1_q; dn_q <= p1n_q; gy_q <= p1_q;
				end else begin
					d_q <= p2_q; dn_q <= p2n_q; gy_q <= p2_q;
				end
				if (op_q == OP_CMP) begin
					res_q.equal <= (sum_mag == '0);
					res_q.less  <= (sum_mag != '0) && (sum_neg != p2n_q);
				end
			end
			S_GCD: begin
				if (gy_q == '0)
					g_q <= gx_q;
			end
			S_GWT: begin
				if (div_done) begin
					gx_q <= gy_q;
					gy_q <= div_r;
				end
			end
			S_DNW: if (div_done) nr_q <= div_q;
			S_DDW: begin
				if (div_done) begin
					if (ovf) begin
						res_q.status <= ST_OVF;
					end else begin
						res_q.res_num <= neg_res ? 32'(~nr_q + 1) : nr_q[31:0];
						res_q.res_den <= div_q[30:0];
					end
				end
			end
			S_OUT: begin
				if (op_q != OP_CMP && n_q == '0) begin
					res_q.res_num <= '0;
					res_q.res_den <= 31'd1;
				end
			end
			default: begin
			end
		endcase
	end

	assign busy = (state_q != S_IDLE) || done_q;
	assign done = done_q;
	assign res  = res_q;

	a_idle_no_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_OUT) |=> done_q) else $error("result word lost");
	a_div_only_in_seq: assert property (@(posedge clk) disable iff (!arst_n)
		dctl.done |-> (state_q == S_GWT || state_q == S_DNW || state_q == S_DDW))
		else $error("divider finished outside a wait state");
	a_busy_on_start: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && cmd.opcode <= OP_CMP) |=> busy)
		else $error("accepted word not busy");

endmodule
